### sv/lbci_pkg.sv
// Package for the LED blink count indicator.
// Holds colour codes, mix step encoding, hold times and beat field layout.
// No dependencies.
`default_nettype none

package lbci_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned NOW_W    = 32;
  localparam int unsigned TOTAL_W  = 8;
  localparam int unsigned COLOUR_W = 3;
  localparam int unsigned MS_W     = 16;

  localparam int unsigned IN_FIELDS_W = NOW_W + TOTAL_W + COLOUR_W + 3 * MS_W;
  localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam int unsigned HOLD_W = 7;

  typedef enum logic [COLOUR_W-1:0] {
    COL_RED    = 3'd0,
    COL_GREEN  = 3'd1,
    COL_ORANGE = 3'd2,
    COL_RG50   = 3'd3,
    COL_RG100  = 3'd4
  } colour_t;

  typedef enum logic [1:0] {
    MIX_OFF   = 2'd0,
    MIX_GREEN = 2'd1,
    MIX_RED   = 2'd2,
    MIX_HOLD  = 2'd3
  } mix_phase_t;

  localparam logic [HOLD_W-1:0] HOLD_ORANGE_GREEN = 7'd2;
  localparam logic [HOLD_W-1:0] HOLD_ORANGE_RED   = 7'd1;
  localparam logic [HOLD_W-1:0] HOLD_SHORT        = 7'd50;
  localparam logic [HOLD_W-1:0] HOLD_LONG         = 7'd100;

endpackage

`default_nettype wire

### sv/led_blink_count_indicator.sv
// LED blink count indicator, top level.
// One poll beat in, one LED level beat out; uses lbci_pkg.
//
//   channel | direction | tdata fields, lowest bit up
//   in_     | slave     | now_ms[31:0] blink_total[39:32] colour[42:40]
//           |           | dark_time[58:43] lit_time[74:59] group_pause[90:75]
//   out_    | master    | red_led[0] green_led[1] blink_active[2]
//
// One beat per cycle sustained while out_tready holds; input register, then
// state update and result register in the same cycle.
// The state update is a few TIME_BITS subtract/compare paths on the stored beat.
// rst_n clears the blink state and both valid flags; LEDs are off after reset.
// A stalled output holds the result register and a full input register; the input
// register takes a beat when empty or whenever the state update can advance.
`default_nettype none

module led_blink_count_indicator #(
  parameter int unsigned TIME_BITS = lbci_pkg::TIME_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // now_ms, blink_total, colour, dark_time, lit_time, group_pause, zero fill
  input  wire logic [lbci_pkg::IN_DATA_W-1:0]   in_tdata,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // red_led, green_led, blink_active, zero fill
  output      logic [lbci_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import lbci_pkg::*;

  localparam int unsigned O_TOTAL  = NOW_W;
  localparam int unsigned O_COLOUR = O_TOTAL + TOTAL_W;
  localparam int unsigned O_DARK   = O_COLOUR + COLOUR_W;
  localparam int unsigned O_LIT    = O_DARK + MS_W;
  localparam int unsigned O_PAUSE  = O_LIT + MS_W;

  logic                 in_v_r;
  logic [NOW_W-1:0]     in_now_r;
  logic [TOTAL_W-1:0]   in_total_r;
  logic [COLOUR_W-1:0]  in_colour_r;
  logic [MS_W-1:0]      in_dark_r;
  logic [MS_W-1:0]      in_lit_r;
  logic [MS_W-1:0]      in_pause_r;

  logic [TIME_BITS-1:0] phase_start_r, phase_start_nxt;
  logic [TIME_BITS-1:0] mix_start_r, mix_start_nxt;
  logic                 lit_r, lit_nxt;
  logic [TOTAL_W-1:0]   blinks_done_r, blinks_done_nxt;
  mix_phase_t           mix_phase_r, mix_phase_nxt;
  logic                 red_r, red_nxt;
  logic                 green_r, green_nxt;
  logic                 out_v_r;

  logic                 step_en;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] since_phase;
  logic [TIME_BITS-1:0] since_mix;
  logic [HOLD_W-1:0]    green_hold;
  logic [HOLD_W-1:0]    red_hold;
  logic                 is_mix;
  logic                 start_blink;
  logic                 end_lit;
  logic                 restart;
  logic                 mix_green_done;
  logic                 mix_red_done;

  assign step_en   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step_en;

  generate
    if (TIME_BITS <= NOW_W) begin : g_now_trunc
      assign now_w = in_now_r[TIME_BITS-1:0];
    end else begin : g_now_ext
      assign now_w = {{(TIME_BITS - NOW_W){1'b0}}, in_now_r};
    end
  endgenerate

  assign since_phase = now_w - phase_start_r;
  assign since_mix   = now_w - mix_start_r;

  always_comb begin
    case (in_colour_r)
      COL_ORANGE: begin
        green_hold = HOLD_ORANGE_GREEN;
        red_hold   = HOLD_ORANGE_RED;
      end
      COL_RG100: begin
        green_hold = HOLD_LONG;
        red_hold   = HOLD_LONG;
      end
      default: begin
        green_hold = HOLD_SHORT;
        red_hold   = HOLD_SHORT;
      end
    endcase
  end

  assign is_mix = (in_colour_r == COL_ORANGE) || (in_colour_r == COL_RG50) ||
                  (in_colour_r == COL_RG100);

  assign start_blink = !lit_r && (blinks_done_r < in_total_r) &&
                       ((in_dark_r == '0) || (since_phase > TIME_BITS'(in_dark_r)));
  assign end_lit     = lit_r && (since_phase > TIME_BITS'(in_lit_r));
  assign restart     = !lit_r && !start_blink &&
                       (since_phase > TIME_BITS'(in_pause_r)) &&
                       (blinks_done_r >= in_total_r);

  assign mix_green_done = since_mix >= TIME_BITS'(green_hold);
  assign mix_red_done   = since_mix >= TIME_BITS'(red_hold);

  // Mix step next state
  always_comb begin
    mix_phase_nxt = mix_phase_r;
    mix_start_nxt = mix_start_r;
    if (start_blink && is_mix) begin
      case (mix_phase_r)
        MIX_OFF: begin
          mix_phase_nxt = MIX_GREEN;
          mix_start_nxt = now_w;
        end
        MIX_GREEN: begin
          if (mix_green_done) begin
            mix_phase_nxt = MIX_RED;
            mix_start_nxt = now_w;
          end
        end
        MIX_RED: begin
          if (mix_red_done) begin
            mix_phase_nxt = MIX_OFF;
            mix_start_nxt = now_w;
          end
        end
        default: begin
          mix_phase_nxt = mix_phase_r;
        end
      endcase
    end
  end

  // LED levels and blink bookkeeping
  always_comb begin
    red_nxt         = red_r;
    green_nxt       = green_r;
    lit_nxt         = lit_r;
    phase_start_nxt = phase_start_r;
    blinks_done_nxt = blinks_done_r;
    if (start_blink) begin
      lit_nxt         = 1'b1;
      phase_start_nxt = now_w;
      blinks_done_nxt = blinks_done_r + TOTAL_W'(1);
      case (in_colour_r)
        COL_RED:   red_nxt = 1'b1;
        COL_GREEN: green_nxt = 1'b1;
        COL_ORANGE, COL_RG50, COL_RG100: begin
          case (mix_phase_r)
            MIX_OFF: green_nxt = 1'b1;
            MIX_GREEN: begin
              if (mix_green_done) begin
                green_nxt = 1'b0;
                red_nxt   = 1'b1;
              end
            end
            MIX_RED: begin
              if (mix_red_done) begin
                red_nxt = 1'b0;
              end
            end
            default: red_nxt = red_r;
          endcase
        end
        default: red_nxt = red_r;
      endcase
    end else if (end_lit) begin
      lit_nxt         = 1'b0;
      phase_start_nxt = now_w;
      if (in_lit_r != '0) begin
        red_nxt   = 1'b0;
        green_nxt = 1'b0;
      end
    end else if (restart) begin
      blinks_done_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_now_r    <= in_tdata[NOW_W-1:0];
      in_total_r  <= in_tdata[O_TOTAL +: TOTAL_W];
      in_colour_r <= in_tdata[O_COLOUR +: COLOUR_W];
      in_dark_r   <= in_tdata[O_DARK +: MS_W];
      in_lit_r    <= in_tdata[O_LIT +: MS_W];
      in_pause_r  <= in_tdata[O_PAUSE +: MS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_start_r <= '0;
      mix_start_r   <= '0;
      lit_r         <= 1'b0;
      blinks_done_r <= '0;
      mix_phase_r   <= MIX_OFF;
      red_r         <= 1'b0;
      green_r       <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      if (step_en) begin
        phase_start_r <= phase_start_nxt;
        mix_start_r   <= mix_start_nxt;
        lit_r         <= lit_nxt;
        blinks_done_r <= blinks_done_nxt;
        mix_phase_r   <= mix_phase_nxt;
        red_r         <= red_nxt;
        green_r       <= green_nxt;
        out_v_r       <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W - 3){1'b0}}, lit_r, green_r, red_r};

  a_blink_counts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lit_r) |-> blinks_done_r == $past(blinks_done_r) + TOTAL_W'(1))
    else $error("blink start without count advance");

  a_lit_end_time: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(lit_r) && $past(step_en) |->
      phase_start_r == $past(now_w))
    else $error("lit end did not restart phase timer");

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_v_r)
    else $error("state update without result beat");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step_en |=> in_v_r && $stable(lit_r) && $stable(blinks_done_r))
    else $error("state moved during output stall");

endmodule

`default_nettype wire
